// ===== rtl/bblru_pkg.sv =====
package bblru_pkg;
   localparam int ENTRIES = 16;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SIDE_W = 13;
   localparam int SIZE_W = 27;
   localparam int MAX_SIDE = 4096;
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = {SIZE_W{1'b1}};
   localparam logic [4:0] EVICT_LIMIT = 5'd31;
   localparam logic [31:0] BUDGET_RESET = 32'd67108864;

   typedef enum logic [2:0] {
      MODE_PUT = 3'd0,
      MODE_GET = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_CLEAR = 3'd3,
      MODE_MARK = 3'd4,
      MODE_MARK_ALL = 3'd5,
      MODE_CLEAN = 3'd6,
      MODE_EVICT = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCAN,
      ST_DECIDE,
      ST_DROP,
      ST_FIND_OLD,
      ST_INSERT,
      ST_CLEAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [31:0] key_tag;
      logic [SIDE_W-1:0] image_width;
      logic [SIDE_W-1:0] image_height;
   } req_word_type;

   typedef struct packed {
      logic status;
      logic found;
      logic entry_dirty;
      logic [SIZE_W-1:0] entry_bytes;
      logic [4:0] evicted_count;
      logic [31:0] memory_in_use;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_word_type;
endpackage

// ===== rtl/bblru_if.sv =====
interface bblru_req_if;
   import bblru_pkg::*;
   logic valid;
   logic ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bblru_rsp_if;
   import bblru_pkg::*;
   logic valid;
   logic ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/byte_budget_lru_cache.sv =====
// Image cache tag table held within a byte budget, least-recently-used eviction.
// req: one word per operation (mode, key_tag, image_width, image_height),
//   accepted when req.valid and req.ready are both high.
// rsp: one word per operation, held in an output register until taken.
// csr: APB-style port, byte_budget at address 0; pready is always high.
// Operation: an operation walks the 16-entry table one entry per cycle through a
//   single compare/update datapath. Every operation starts with a lookup pass;
//   each eviction adds an oldest-entry scan plus a drop step; a put adds a
//   multiply, a fit-check and an insert step; clean dirty adds a second pass
//   that drops the dirty entries. The result word is loaded in the done state.
// req.ready is high only while idle; the next word can be taken in the cycle
//   after the result is loaded.
// Reset: all entries invalid, byte count and hit/miss totals zero, budget
//   67108864. No clearing pass is needed.
// Stall: when rsp.ready is low the result word holds; one more word may be
//   taken and run, then it holds in its final step until the register frees.
module byte_budget_lru_cache (
   input  logic clock,
   input  logic reset,
   bblru_req_if.sink req,
   bblru_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import bblru_pkg::*;

   // table storage: valid bits reset, payload does not
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] key_ff [ENTRIES];
   logic [SIZE_W-1:0] size_ff [ENTRIES];
   logic [ENTRIES-1:0] dirty_ff;
   logic [RANK_W-1:0] rank_ff [ENTRIES];

   state_type state_ff, state_in;
   req_word_type op_ff, op_in;
   logic [31:0] budget_ff, budget_in;
   logic [31:0] used_ff, used_in;
   logic [31:0] hits_ff, hits_in, miss_ff, miss_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic best_ok_ff, best_ok_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   logic [4:0] evict_ff, evict_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   // per-cycle entry update requests
   logic do_drop, do_touch, do_insert, do_mark, do_mark_all, do_clear;
   logic [IDX_W-1:0] tgt;
   logic [RANK_W-1:0] tgt_rank;

   logic last;
   logic [CNT_W-1:0] nvalid;
   logic [IDX_W-1:0] free_idx;
   logic free_ok;
   logic [25:0] wsat, hsat;
   logic [SIZE_W+5:0] prod;
   logic cfg_wr;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? budget_ff : 32'd0;
   assign budget_in = (cfg_wr && csr_paddr == 2'd0) ? csr_pwdata : budget_ff;

   assign last = (ptr_ff == IDX_W'(ENTRIES - 1));
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_comb begin
      nvalid = '0;
      free_ok = 1'b0;
      free_idx = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         nvalid = nvalid + CNT_W'(valid_ff[j]);
         if (!valid_ff[j]) begin
            free_ok = 1'b1;
            free_idx = IDX_W'(j);
         end
      end
   end

   always_comb begin
      wsat = (op_ff.image_width > SIDE_W'(MAX_SIDE)) ? 26'(MAX_SIDE)
                                                      : 26'(op_ff.image_width);
      hsat = (op_ff.image_height > SIDE_W'(MAX_SIDE)) ? 26'(MAX_SIDE)
                                                       : 26'(op_ff.image_height);
      prod = (SIZE_W+6)'(wsat * hsat) << 2;
   end

   always_comb begin
      logic over;
      state_in = state_ff;
      op_in = op_ff;
      used_in = used_ff;
      hits_in = hits_ff;
      miss_in = miss_ff;
      ptr_in = ptr_ff;
      hit_idx_in = hit_idx_ff;
      hit_in = hit_ff;
      best_in = best_ff;
      best_ok_in = best_ok_ff;
      need_in = need_ff;
      evict_in = evict_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      do_drop = 1'b0;
      do_touch = 1'b0;
      do_insert = 1'b0;
      do_mark = 1'b0;
      do_mark_all = 1'b0;
      do_clear = 1'b0;
      tgt = hit_idx_ff;
      over = 1'b0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.data;
               ptr_in = '0;
               hit_in = 1'b0;
               evict_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // key lookup, one entry per cycle
            if (!hit_ff && valid_ff[ptr_ff] && key_ff[ptr_ff] == op_ff.key_tag) begin
               hit_in = 1'b1;
               hit_idx_in = ptr_ff;
            end
            ptr_in = ptr_ff + 1'b1;
            if (last) state_in = ST_DECIDE;
            if (mode_type'(op_ff.mode) == MODE_CLEAN && last) begin
               ptr_in = '0;
               state_in = ST_CLEAN;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            case (mode_type'(op_ff.mode))
               MODE_PUT: begin
                  if (op_ff.image_width != '0 && op_ff.image_height != '0) begin
                     state_in = ST_MUL;
                  end
               end
               MODE_GET: begin
                  if (hit_ff) begin
                     do_touch = 1'b1;
                     if (hits_ff != '1) hits_in = hits_ff + 1'b1;
                  end else if (miss_ff != '1) begin
                     miss_in = miss_ff + 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  if (hit_ff) begin
                     do_drop = 1'b1;
                     used_in = used_ff - 32'(size_ff[hit_idx_ff]);
                  end
               end
               MODE_CLEAR: begin
                  do_clear = 1'b1;
                  used_in = '0;
               end
               MODE_MARK: do_mark = hit_ff;
               MODE_MARK_ALL: do_mark_all = 1'b1;
               MODE_EVICT: begin
                  need_in = '0;
                  ptr_in = '0;
                  best_ok_in = 1'b0;
                  state_in = ST_DROP;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL: begin
            need_in = (prod > (SIZE_W+6)'(SIZE_LIMIT)) ? SIZE_LIMIT : prod[SIZE_W-1:0];
            if (hit_ff) begin
               do_drop = 1'b1;
               used_in = used_ff - 32'(size_ff[hit_idx_ff]);
            end
            state_in = ST_DROP;
         end
         ST_DROP: begin
            // check whether another eviction is needed, then drop the oldest
            if (best_ok_ff) begin
               do_drop = 1'b1;
               tgt = best_ff;
               used_in = used_ff - 32'(size_ff[best_ff]);
               if (evict_ff != EVICT_LIMIT) evict_in = evict_ff + 1'b1;
               best_ok_in = 1'b0;
            end else begin
               over = (mode_type'(op_ff.mode) == MODE_PUT)
                  ? ({1'b0, used_ff} + 33'(need_ff) > {1'b0, budget_ff})
                  : (used_ff > budget_ff);
               if (nvalid != '0 && (over ||
                   (mode_type'(op_ff.mode) == MODE_PUT && !free_ok))) begin
                  ptr_in = '0;
                  state_in = ST_FIND_OLD;
               end else begin
                  state_in = (mode_type'(op_ff.mode) == MODE_PUT) ? ST_INSERT : ST_DONE;
               end
            end
         end
         ST_FIND_OLD: begin
            if (valid_ff[ptr_ff] && (!best_ok_ff || rank_ff[ptr_ff] > rank_ff[best_ff])) begin
               best_in = ptr_ff;
               best_ok_in = 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (last) state_in = ST_DROP;
         end
         ST_INSERT: begin
            do_insert = 1'b1;
            tgt = free_idx;
            used_in = used_ff + 32'(need_ff);
            state_in = ST_DONE;
         end
         ST_CLEAN: begin
            // drop dirty entries one per cycle
            if (valid_ff[ptr_ff] && dirty_ff[ptr_ff]) begin
               do_drop = 1'b1;
               tgt = ptr_ff;
               used_in = used_ff - 32'(size_ff[ptr_ff]);
               if (evict_ff != EVICT_LIMIT) evict_in = evict_ff + 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (last) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold here while the previous result word still waits
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = (mode_type'(op_ff.mode) == MODE_PUT) &&
                               (op_ff.image_width == '0 || op_ff.image_height == '0);
               rsp_in.found = hit_ff && (mode_type'(op_ff.mode) == MODE_PUT ||
                              mode_type'(op_ff.mode) == MODE_GET ||
                              mode_type'(op_ff.mode) == MODE_REMOVE ||
                              mode_type'(op_ff.mode) == MODE_MARK);
               rsp_in.entry_dirty = (mode_type'(op_ff.mode) == MODE_GET) && hit_ff &&
                                    dirty_ff[hit_idx_ff];
               rsp_in.entry_bytes = ((mode_type'(op_ff.mode) == MODE_GET) && hit_ff)
                                    ? size_ff[hit_idx_ff] : '0;
               rsp_in.evicted_count = evict_ff;
               rsp_in.memory_in_use = used_ff;
               rsp_in.hit_total = hits_ff;
               rsp_in.miss_total = miss_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign tgt_rank = rank_ff[tgt];

   // entry update: all ranks shift in parallel, one entry's fields written
   always_comb begin
      valid_in = valid_ff;
      if (do_clear) valid_in = '0;
      if (do_drop) valid_in[tgt] = 1'b0;
      if (do_insert) valid_in[tgt] = 1'b1;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ENTRIES; j++) begin
         if (valid_ff[j]) begin
            if (do_drop && rank_ff[j] > tgt_rank) rank_ff[j] <= rank_ff[j] - 1'b1;
            if (do_touch && IDX_W'(j) != tgt && rank_ff[j] < tgt_rank)
               rank_ff[j] <= rank_ff[j] + 1'b1;
            if (do_insert) rank_ff[j] <= rank_ff[j] + 1'b1;
            if (do_mark_all) dirty_ff[j] <= 1'b1;
         end
      end
      if (do_touch) rank_ff[tgt] <= '0;
      if (do_mark) dirty_ff[tgt] <= 1'b1;
      if (do_insert) begin
         key_ff[tgt] <= op_ff.key_tag;
         size_ff[tgt] <= need_ff;
         dirty_ff[tgt] <= 1'b0;
         rank_ff[tgt] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ptr_ff <= ptr_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff <= hit_in;
      best_ff <= best_in;
      need_ff <= need_in;
      evict_ff <= evict_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         budget_ff <= BUDGET_RESET;
         used_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         best_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         budget_ff <= budget_in;
         used_ff <= used_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         best_ok_ff <= best_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("result word changed while waiting");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("result lost");
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({do_drop, do_touch, do_insert, do_mark, do_mark_all, do_clear}))
      else $error("two table updates at once");
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      do_insert |-> free_ok)
      else $error("insert into full table");
`endif
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bblru_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   bblru_req_if req_if ();
   bblru_rsp_if rsp_if ();

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   byte_budget_lru_cache uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   localparam logic [1:0] ADDR_BUDGET = 2'd0;

   // Shadow copy of the tag table, advanced once per accepted request word.
   logic              shd_valid [ENTRIES];
   logic [31:0]       shd_key   [ENTRIES];
   logic [SIZE_W-1:0] shd_size  [ENTRIES];
   logic              shd_dirty [ENTRIES];
   int                shd_rank  [ENTRIES];
   logic [31:0]       shd_bytes;
   logic [31:0]       shd_hits;
   logic [31:0]       shd_misses;
   logic [31:0]       shd_budget;

   rsp_word_type expected_words[$];
   int mismatch_count = 0;
   bit long_hold_req = 1'b0;

   // Directed stimulus: a row either carries a typed-in result or defers to the
   // shadow table.
   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type result;
   } plan_row_type;

   plan_row_type plan_rows[$];

   function automatic void add_row(plan_row_type row);
      plan_rows.insert(plan_rows.size(), row);
   endfunction

   function automatic rsp_word_type rsp_of(logic st, logic fnd, logic drt,
                                           logic [SIZE_W-1:0] nbytes, logic [4:0] ev,
                                           logic [31:0] mem, logic [31:0] hit,
                                           logic [31:0] miss);
      rsp_word_type r;
      r.status = st;
      r.found = fnd;
      r.entry_dirty = drt;
      r.entry_bytes = nbytes;
      r.evicted_count = ev;
      r.memory_in_use = mem;
      r.hit_total = hit;
      r.miss_total = miss;
      return r;
   endfunction

   function automatic req_word_type req_of(mode_type m, logic [31:0] k,
                                           logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
      req_word_type r;
      r.mode = m;
      r.key_tag = k;
      r.image_width = w;
      r.image_height = h;
      return r;
   endfunction

   function automatic int find_key(logic [31:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (shd_valid[i] && shd_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int i);
      int r;
      r = shd_rank[i];
      shd_valid[i] = 1'b0;
      shd_bytes = shd_bytes - 32'(shd_size[i]);
      for (int j = 0; j < ENTRIES; j++)
         if (shd_valid[j] && shd_rank[j] > r) shd_rank[j]--;
   endfunction

   // Drop the least recently used entry; false when the table is empty.
   function automatic bit evict_oldest(ref logic [4:0] ev);
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (shd_valid[i] && (best < 0 || shd_rank[i] > shd_rank[best])) best = i;
      if (best < 0) return 1'b0;
      drop_slot(best);
      if (ev < EVICT_LIMIT) ev++;
      return 1'b1;
   endfunction

   function automatic int open_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!shd_valid[i]) return i;
      return -1;
   endfunction

   // Apply one operation to the shadow table and return the result word.
   function automatic rsp_word_type apply_cache_op(req_word_type w);
      rsp_word_type r;
      int i, slot, rr;
      logic [4:0] ev;
      logic [63:0] sw, sh, nbytes;
      r = '0;
      ev = '0;
      case (mode_type'(w.mode))
         MODE_PUT: begin
            i = find_key(w.key_tag);
            r.found = (i >= 0);
            if (w.image_width == 0 || w.image_height == 0) begin
               r.status = 1'b1;
            end else begin
               sw = (w.image_width > MAX_SIDE) ? 64'(MAX_SIDE) : 64'(w.image_width);
               sh = (w.image_height > MAX_SIDE) ? 64'(MAX_SIDE) : 64'(w.image_height);
               nbytes = sw * sh * 4;
               if (nbytes > 64'(SIZE_LIMIT)) nbytes = 64'(SIZE_LIMIT);
               if (i >= 0) drop_slot(i);
               while (64'(shd_bytes) + nbytes > 64'(shd_budget))
                  if (!evict_oldest(ev)) break;
               slot = open_slot();
               if (slot < 0) begin
                  void'(evict_oldest(ev));
                  slot = open_slot();
               end
               if (slot >= 0) begin
                  for (int j = 0; j < ENTRIES; j++)
                     if (shd_valid[j]) shd_rank[j]++;
                  shd_valid[slot] = 1'b1;
                  shd_key[slot] = w.key_tag;
                  shd_size[slot] = nbytes[SIZE_W-1:0];
                  shd_dirty[slot] = 1'b0;
                  shd_rank[slot] = 0;
                  shd_bytes = shd_bytes + 32'(nbytes);
               end
            end
         end
         MODE_GET: begin
            i = find_key(w.key_tag);
            if (i >= 0) begin
               r.found = 1'b1;
               rr = shd_rank[i];
               for (int j = 0; j < ENTRIES; j++)
                  if (j != i && shd_valid[j] && shd_rank[j] < rr) shd_rank[j]++;
               shd_rank[i] = 0;
               r.entry_dirty = shd_dirty[i];
               r.entry_bytes = shd_size[i];
               if (shd_hits != '1) shd_hits++;
            end else if (shd_misses != '1) begin
               shd_misses++;
            end
         end
         MODE_REMOVE: begin
            i = find_key(w.key_tag);
            if (i >= 0) begin
               r.found = 1'b1;
               drop_slot(i);
            end
         end
         MODE_CLEAR: begin
            for (int j = 0; j < ENTRIES; j++) shd_valid[j] = 1'b0;
            shd_bytes = '0;
         end
         MODE_MARK: begin
            i = find_key(w.key_tag);
            if (i >= 0) begin
               r.found = 1'b1;
               shd_dirty[i] = 1'b1;
            end
         end
         MODE_MARK_ALL: begin
            for (int j = 0; j < ENTRIES; j++)
               if (shd_valid[j]) shd_dirty[j] = 1'b1;
         end
         MODE_CLEAN: begin
            for (int j = 0; j < ENTRIES; j++)
               if (shd_valid[j] && shd_dirty[j]) begin
                  drop_slot(j);
                  if (ev < EVICT_LIMIT) ev++;
               end
         end
         default: begin
            while (shd_bytes > shd_budget)
               if (!evict_oldest(ev)) break;
         end
      endcase
      r.evicted_count = ev;
      r.memory_in_use = shd_bytes;
      r.hit_total = shd_hits;
      r.miss_total = shd_misses;
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   int burst_left = 0;

   // Offer one word and hold it until taken; the shadow table moves at the
   // accepting edge, so expectations queue up in acceptance order.
   task automatic send_word(req_word_type w, bit typed, rsp_word_type typed_rsp);
      rsp_word_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!req_if.ready);
      predicted = apply_cache_op(w);
      expected_words.insert(expected_words.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the end
   // of the access cycle.
   task automatic write_budget(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_BUDGET;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shd_budget = value;
   endtask

   // ---------------------------------------------------------------- receiver
   int stall_left = 0;
   int pattern_left = 0;
   int pattern_kind = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result word %p", $realtime, rsp_if.data);
         end else begin
            rsp_word_type exp_w, got_w;
            exp_w = expected_words.pop_front();
            got_w = rsp_if.data;
            if (got_w.status !== exp_w.status || got_w.found !== exp_w.found ||
                got_w.entry_dirty !== exp_w.entry_dirty ||
                got_w.entry_bytes !== exp_w.entry_bytes ||
                got_w.evicted_count !== exp_w.evicted_count ||
                got_w.memory_in_use !== exp_w.memory_in_use ||
                got_w.hit_total !== exp_w.hit_total ||
                got_w.miss_total !== exp_w.miss_total) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                           $realtime, exp_w, got_w);
            end
         end
      end
      // One long hold-off so the block fills up and backs up the request side.
      if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         stall_left <= 600;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(20, 200);
            pattern_kind <= $urandom_range(0, 2);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (pattern_kind)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- stimulus
   logic [31:0] key_pool[24];

   function automatic logic [SIDE_W-1:0] pick_side();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return SIDE_W'($urandom_range(0, 8191));
      if (sel == 2) return SIDE_W'($urandom_range(1000, 4096));
      return SIDE_W'($urandom_range(1, 96));
   endfunction

   function automatic req_word_type pick_word();
      int sel;
      mode_type m;
      logic [31:0] k;
      sel = $urandom_range(0, 99);
      if (sel < 40) m = MODE_PUT;
      else if (sel < 70) m = MODE_GET;
      else if (sel < 78) m = MODE_REMOVE;
      else if (sel < 80) m = MODE_CLEAR;
      else if (sel < 88) m = MODE_MARK;
      else if (sel < 91) m = MODE_MARK_ALL;
      else if (sel < 95) m = MODE_CLEAN;
      else m = MODE_EVICT;
      k = ($urandom_range(0, 15) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
      return req_of(m, k, pick_side(), pick_side());
   endfunction

   initial begin
      logic [31:0] budgets[7];
      rsp_word_type none;
      none = '0;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_BUDGET;
      csr_pwdata <= '0;

      for (int i = 0; i < ENTRIES; i++) begin
         shd_valid[i] = 1'b0;
         shd_key[i] = '0;
         shd_size[i] = '0;
         shd_dirty[i] = 1'b0;
         shd_rank[i] = 0;
      end
      shd_bytes = '0;
      shd_hits = '0;
      shd_misses = '0;
      shd_budget = BUDGET_RESET;

      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 24; i++) key_pool[i] = $urandom();

      // Reset table: miss on empty, put with no image, a put that exactly fills
      // the default budget, oversized sides forcing eviction, dirty handling.
      add_row('{req_of(MODE_GET, 32'd5, 13'd0, 13'd0), 1,
                rsp_of(0, 0, 0, 0, 0, 0, 0, 1)});
      add_row('{req_of(MODE_PUT, 32'd5, 13'd0, 13'd10), 1,
                rsp_of(1, 0, 0, 0, 0, 0, 0, 1)});
      add_row('{req_of(MODE_PUT, 32'd5, 13'd4096, 13'd4096), 1,
                rsp_of(0, 0, 0, 0, 0, 32'd67108864, 0, 1)});
      add_row('{req_of(MODE_GET, 32'd5, 13'd0, 13'd0), 1,
                rsp_of(0, 1, 0, 27'd67108864, 0, 32'd67108864, 1, 1)});
      add_row('{req_of(MODE_PUT, 32'd6, 13'h1FFF, 13'h1FFF), 1,
                rsp_of(0, 0, 0, 0, 1, 32'd67108864, 1, 1)});
      add_row('{req_of(MODE_MARK, 32'd6, 13'd0, 13'd0), 1,
                rsp_of(0, 1, 0, 0, 0, 32'd67108864, 1, 1)});
      add_row('{req_of(MODE_GET, 32'd6, 13'd0, 13'd0), 1,
                rsp_of(0, 1, 1, 27'd67108864, 0, 32'd67108864, 2, 1)});
      add_row('{req_of(MODE_CLEAN, 32'd0, 13'd0, 13'd0), 1,
                rsp_of(0, 0, 0, 0, 1, 0, 2, 1)});
      add_row('{req_of(MODE_REMOVE, 32'd6, 13'd0, 13'd0), 1,
                rsp_of(0, 0, 0, 0, 0, 0, 2, 1)});
      add_row('{req_of(MODE_MARK, 32'd6, 13'd0, 13'd0), 1,
                rsp_of(0, 0, 0, 0, 0, 0, 2, 1)});
      // Extreme keys and sides, then the remaining operations on a live table.
      add_row('{req_of(MODE_PUT, 32'hFFFF_FFFF, 13'd1, 13'd1), 0, none});
      add_row('{req_of(MODE_PUT, 32'h0, 13'd4097, 13'd1), 0, none});
      add_row('{req_of(MODE_PUT, 32'hAAAA_AAAA, 13'h0AAA, 13'h1555), 0, none});
      add_row('{req_of(MODE_PUT, 32'h5555_5555, 13'h1555, 13'h0AAA), 0, none});
      add_row('{req_of(MODE_PUT, 32'h0, 13'd2, 13'd3), 0, none});
      add_row('{req_of(MODE_GET, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF), 0, none});
      add_row('{req_of(MODE_MARK_ALL, 32'd0, 13'd0, 13'd0), 0, none});
      add_row('{req_of(MODE_PUT, 32'd7, 13'd8, 13'd8), 0, none});
      add_row('{req_of(MODE_CLEAN, 32'd0, 13'd0, 13'd0), 0, none});
      add_row('{req_of(MODE_EVICT, 32'd0, 13'd0, 13'd0), 0, none});
      add_row('{req_of(MODE_REMOVE, 32'd7, 13'd0, 13'd0), 0, none});
      add_row('{req_of(MODE_PUT, 32'd8, 13'd16, 13'd16), 0, none});
      add_row('{req_of(MODE_CLEAR, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF), 0, none});
      add_row('{req_of(MODE_GET, 32'd8, 13'd0, 13'd0), 0, none});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_rows[r]) send_word(plan_rows[r].word, plan_rows[r].typed,
                                       plan_rows[r].result);

      // Random phases, each under its own budget; the extremes come first so a
      // zero budget and an unlimited one both see fill and eviction traffic.
      budgets[0] = 32'd0;
      budgets[1] = 32'hFFFF_FFFF;
      budgets[2] = 32'd65536;
      budgets[3] = 32'd20000;
      budgets[4] = $urandom_range(1000, 400000);
      budgets[5] = 32'd4096;
      budgets[6] = BUDGET_RESET;
      for (int p = 0; p < 7; p++) begin
         wait_drained();
         write_budget(budgets[p]);
         for (int n = 0; n < 175; n++) begin
            if (p == 3 && n == 60) long_hold_req = 1'b1;
            // Budget may now be below use: evict-if-needed trims the table.
            if (n == 0 && p == 5) send_word(req_of(MODE_EVICT, 32'd0, 13'd0, 13'd0), 0, none);
            send_word(pick_word(), 0, none);
         end
      end

      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/bblru_pkg.sv
rtl/bblru_if.sv
rtl/byte_budget_lru_cache.sv
dv/tb_top.sv
